### src/cbor_hd_pkg.sv
// shared types and constants of the cbor head decoder
package cbor_hd_pkg;

	typedef enum logic [2:0] {
		MT_UINT   = 3'd0,
		MT_NINT   = 3'd1,
		MT_BSTR   = 3'd2,
		MT_TSTR   = 3'd3,
		MT_ARRAY  = 3'd4,
		MT_MAP    = 3'd5,
		MT_TAG    = 3'd6,
		MT_SIMPLE = 3'd7
	} major_t;

	localparam logic [4:0]  INFO_ONE_BYTE    = 5'd24;
	localparam logic [4:0]  INFO_EIGHT_BYTES = 5'd27;
	localparam logic [63:0] ALL_ONES         = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam int          QUEUE_DEPTH      = 2;

	typedef struct packed {
		major_t      major_type;
		logic [63:0] argument;
		logic        argument_valid;
		logic [3:0]  head_length;
	} head_t;

	typedef struct packed {
		logic  valid;
		head_t head;
	} head_push_t;

endpackage

### src/cbor_hd_ifs.sv
// byte stream and decoded head channel interfaces
interface cbor_hd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

interface cbor_hd_head_if;
	logic        valid;
	logic        ready;
	logic [2:0]  major_type;
	logic [63:0] argument;
	logic        argument_valid;
	logic [3:0]  head_length;
	logic [63:0] total_length;
	logic        total_known;
	logic        supported;

	modport source (output valid, output major_type, output argument, output argument_valid,
		output head_length, output total_length, output total_known, output supported,
		input ready);
	modport sink (input valid, input major_type, input argument, input argument_valid,
		input head_length, input total_length, input total_known, input supported,
		output ready);
endinterface

### src/cbor_hd_front.sv
// front end: takes bytes, classifies initial bytes and collects argument bytes
module cbor_hd_front (
	input  logic                    clk,
	input  logic                    arst_n,
	cbor_hd_byte_if.sink            data,
	input  logic                    push_ready,
	output cbor_hd_pkg::head_push_t push
);

	logic                collecting_q, collecting_d;
	logic [3:0]          left_q, left_d;
	logic [63:0]         accum_q, accum_d;
	cbor_hd_pkg::major_t type_q, type_d;
	logic [3:0]          hlen_q, hlen_d;

	logic                accept;
	cbor_hd_pkg::major_t mt;
	logic [4:0]          info;
	logic                multi;
	logic [63:0]         accum_next;
	logic [3:0]          left_dec;
	logic [3:0]          n_bytes;

	assign data.ready = push_ready;
	assign accept     = data.valid && data.ready;
	assign mt         = cbor_hd_pkg::major_t'(data.data_byte[7:5]);
	assign info       = data.data_byte[4:0];
	assign accum_next = {accum_q[55:0], data.data_byte};
	assign left_dec   = (left_q != 4'd0) ? left_q - 4'd1 : 4'd0;
	assign n_bytes    = 4'd1 << info[1:0];

	always_comb begin
		multi = 1'b0;
		case (mt)
			cbor_hd_pkg::MT_UINT, cbor_hd_pkg::MT_BSTR,
			cbor_hd_pkg::MT_TSTR, cbor_hd_pkg::MT_ARRAY: multi = 1'b1;
			default: multi = 1'b0;
		endcase
	end

	always_comb begin
		collecting_d = collecting_q;
		left_d       = left_q;
		accum_d      = accum_q;
		type_d       = type_q;
		hlen_d       = hlen_q;
		push.valid               = 1'b0;
		push.head.major_type     = mt;
		push.head.argument       = cbor_hd_pkg::ALL_ONES;
		push.head.argument_valid = 1'b0;
		push.head.head_length    = 4'd1;
		if (accept) begin
			if (collecting_q) begin
				accum_d = accum_next;
				left_d  = left_dec;
				if (left_dec == 4'd0) begin
					collecting_d             = 1'b0;
					push.valid               = 1'b1;
					push.head.major_type     = type_q;
					push.head.argument       = accum_next;
					push.head.argument_valid = 1'b1;
					push.head.head_length    = hlen_q;
				end
			end else if ((multi || mt == cbor_hd_pkg::MT_TAG)
					&& info < cbor_hd_pkg::INFO_ONE_BYTE) begin
				push.valid               = 1'b1;
				push.head.argument       = {59'd0, info};
				push.head.argument_valid = 1'b1;
			end else if (multi && info <= cbor_hd_pkg::INFO_EIGHT_BYTES) begin
				collecting_d = 1'b1;
				left_d       = n_bytes;
				accum_d      = 64'd0;
				type_d       = mt;
				hlen_d       = n_bytes + 4'd1;
			end else begin
				push.valid = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			collecting_q <= 1'b0;
			left_q       <= 4'd0;
		end else begin
			collecting_q <= collecting_d;
			left_q       <= left_d;
		end
	end

	always_ff @(posedge clk) begin
		accum_q <= accum_d;
		type_q  <= type_d;
		hlen_q  <= hlen_d;
	end

`ifndef ASSERT_OFF
	a_collect_left: assert property (@(posedge clk) disable iff (!arst_n)
		collecting_q |-> left_q != 4'd0)
		else $error("collecting with no bytes left");

	a_push_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> accept)
		else $error("head pushed without an accepted beat");

	a_last_byte_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && collecting_q && left_q == 4'd1) |-> push.valid ##1 !collecting_q)
		else $error("last argument byte did not close the head");
`endif

endmodule

### src/cbor_hd_queue.sv
// small head queue between front and back end
module cbor_hd_queue #(
	parameter int Depth = cbor_hd_pkg::QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push_valid,
	input  cbor_hd_pkg::head_t push_data,
	output logic               push_ready,
	output logic               pop_valid,
	output cbor_hd_pkg::head_t pop_data,
	input  logic               pop_ready
);

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	cbor_hd_pkg::head_t mem_q [Depth];
	logic [PtrW-1:0]    wr_q, rd_q;
	logic [CntW-1:0]    count_q;
	logic               do_push, do_pop;

	assign push_ready = count_q != CntW'(Depth);
	assign pop_valid  = count_q != '0;
	assign pop_data   = mem_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(Depth))
		else $error("queue count past depth");

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count missed a push");
`endif

endmodule

### src/cbor_hd_back.sv
// back end: totals per major type and the output register
module cbor_hd_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pop_valid,
	input  cbor_hd_pkg::head_t pop_data,
	output logic               pop_ready,
	cbor_hd_head_if.source     result
);

	logic        valid_q;
	logic [2:0]  type_q;
	logic [63:0] arg_q, total_q;
	logic        arg_valid_q, known_q, sup_q;
	logic [3:0]  hlen_q;

	logic [63:0] arg_d, total_d;
	logic        arg_valid_d, known_d, sup_d;
	logic        load;

	assign pop_ready = !valid_q || result.ready;
	assign load      = pop_valid && pop_ready;

	always_comb begin
		arg_d       = pop_data.argument;
		arg_valid_d = pop_data.argument_valid;
		known_d     = 1'b1;
		sup_d       = 1'b1;
		total_d     = 64'd0;
		case (pop_data.major_type)
			cbor_hd_pkg::MT_UINT: total_d = {60'd0, pop_data.head_length};
			cbor_hd_pkg::MT_BSTR, cbor_hd_pkg::MT_TSTR:
				total_d = {60'd0, pop_data.head_length} + pop_data.argument;
			cbor_hd_pkg::MT_ARRAY: begin
				total_d = cbor_hd_pkg::ALL_ONES;
				known_d = 1'b0;
			end
			cbor_hd_pkg::MT_TAG: total_d = pop_data.argument;
			default: begin
				sup_d       = 1'b0;
				arg_d       = cbor_hd_pkg::ALL_ONES;
				arg_valid_d = 1'b0;
				total_d     = 64'd0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop_ready) begin
			valid_q <= pop_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			type_q      <= pop_data.major_type;
			arg_q       <= arg_d;
			arg_valid_q <= arg_valid_d;
			hlen_q      <= pop_data.head_length;
			total_q     <= total_d;
			known_q     <= known_d;
			sup_q       <= sup_d;
		end
	end

	assign result.valid          = valid_q;
	assign result.major_type     = type_q;
	assign result.argument       = arg_q;
	assign result.argument_valid = arg_valid_q;
	assign result.head_length    = hlen_q;
	assign result.total_length   = total_q;
	assign result.total_known    = known_q;
	assign result.supported      = sup_q;

endmodule

### src/cbor_head_decoder_unit.sv
// top level of the cbor head decoder
// usage:
//   data carries one byte of a cbor head stream per beat; result carries one
//   decoded head per beat: major type, argument, head length and total length.
//   initial bytes are classified and argument bytes shifted in by the front end,
//   finished heads go through a small queue to the back end, which forms the
//   total and holds it in the output register.
//   one byte is accepted every cycle while the queue has room; a head leaves
//   on result through the queue and then the output register, so a stream of
//   one-byte heads runs at one head per cycle while result takes every beat.
//   bytes that do not finish a head produce nothing on result.
//   when result stalls, the output register holds its beat and the queue
//   fills; once it is full, data.ready drops until result takes a beat.
//   reset clears the collection state, the queue and the output valid, so the
//   next byte is taken as an initial byte.
module cbor_head_decoder_unit #(
	parameter int QueueDepth = cbor_hd_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	cbor_hd_byte_if.sink   data,
	cbor_hd_head_if.source result
);

	cbor_hd_pkg::head_push_t push;
	logic                    push_ready;
	logic                    pop_valid;
	logic                    pop_ready;
	cbor_hd_pkg::head_t      pop_data;

	cbor_hd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.data       (data),
		.push_ready (push_ready),
		.push       (push)
	);

	cbor_hd_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push.valid),
		.push_data  (push.head),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_data   (pop_data),
		.pop_ready  (pop_ready)
	);

	cbor_hd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_data  (pop_data),
		.pop_ready (pop_ready),
		.result    (result)
	);

endmodule
